>>> rtl/fsn_pkg.sv
// Shared constants and helpers for the fast square root pipeline.
// No dependencies; imported by fsn_div, fsn_add and the top level.
`default_nettype none
package fsn_pkg;

	localparam logic [30:0] MAGIC_RESET = 31'h1fbb67a2;
	localparam logic [31:0] CANON_NAN   = 32'h7fc00000;
	localparam logic [30:0] POS_INF     = 31'h7f800000;
	localparam logic [7:0]  EXP_MAX     = 8'hff;

	// leading zero count of a 27-bit word, 27 when all clear
	function automatic logic [4:0] lzc27(input logic [26:0] v);
		logic [4:0] n;
		logic       found;
		n     = 5'd27;
		found = 1'b0;
		for (int i = 26; i >= 0; i--) begin
			if (v[i] && !found) begin
				n     = 5'(26 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

	function automatic logic is_nan(input logic [31:0] b);
		return (b[30:23] == EXP_MAX) && (b[22:0] != 23'd0);
	endfunction

	function automatic logic is_inf(input logic [31:0] b);
		return (b[30:23] == EXP_MAX) && (b[22:0] == 23'd0);
	endfunction

	function automatic logic is_zero(input logic [31:0] b);
		return b[30:0] == 31'd0;
	endfunction

endpackage
`default_nettype wire

>>> rtl/fsn_div.sv
// Pipelined IEEE single-precision divider, round to nearest even.
// Restoring division, two quotient bits per stage; carries a 32-bit side word.
// Depends on fsn_pkg.
`default_nettype none
module fsn_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        adv,
	input  wire logic        in_vld,
	input  wire logic [31:0] num,
	input  wire logic [31:0] den,
	input  wire logic [31:0] aux_in,
	output logic             out_vld,
	output logic      [31:0] quo,
	output logic      [31:0] aux_out
);
	import fsn_pkg::*;

	localparam int DS = 13;

	// stage 0 of these arrays is the unpack register, 1..DS the iterations
	logic              vld_s   [0:DS];
	logic              spec_s  [0:DS];
	logic [31:0]       sbits_s [0:DS];
	logic              sgn_s   [0:DS];
	logic signed [10:0] qe_s   [0:DS];
	logic [25:0]       rem_s   [0:DS];
	logic [23:0]       dm_s    [0:DS];
	logic [25:0]       qt_s    [0:DS];
	logic [31:0]       aux_s   [0:DS];

	// unpack
	logic       xn, en, xi, ei, xz, ez, u_spec, u_sgn, lt;
	logic [31:0] u_sbits;
	logic [4:0]  lzx, lze;
	logic [23:0] mx, me;
	logic signed [9:0] exx, exe;
	logic signed [10:0] u_qe;

	always_comb begin
		xn  = is_nan(num);
		en  = is_nan(den);
		xi  = is_inf(num);
		ei  = is_inf(den);
		xz  = is_zero(num);
		ez  = is_zero(den);
		u_sgn = num[31] ^ den[31];
		lzx = (num[30:23] == 8'd0) ? lzc27({1'b0, num[22:0], 3'b111}) : 5'd0;
		lze = (den[30:23] == 8'd0) ? lzc27({1'b0, den[22:0], 3'b111}) : 5'd0;
		mx  = {num[30:23] != 8'd0, num[22:0]} << lzx;
		me  = {den[30:23] != 8'd0, den[22:0]} << lze;
		exx = $signed({2'b0, (num[30:23] == 8'd0) ? 8'd1 : num[30:23]})
			- $signed({5'b0, lzx});
		exe = $signed({2'b0, (den[30:23] == 8'd0) ? 8'd1 : den[30:23]})
			- $signed({5'b0, lze});
		lt  = mx < me;
		u_qe = {exx[9], exx} - {exe[9], exe} + 11'sd127 - $signed({10'd0, lt});
		u_spec  = 1'b1;
		u_sbits = CANON_NAN;
		if (xn || en || (xi && ei) || (xz && ez)) begin
			u_sbits = CANON_NAN;
		end else if (xi || ez) begin
			u_sbits = {u_sgn, POS_INF};
		end else if (xz || ei) begin
			u_sbits = {u_sgn, 31'd0};
		end else begin
			u_spec = 1'b0;
		end
	end

	function automatic logic [26:0] step(input logic [25:0] r, input logic [23:0] d);
		logic        ge;
		logic [25:0] nr;
		ge = r >= {2'b0, d};
		nr = ge ? r - {2'b0, d} : r;
		return {ge, nr[24:0], 1'b0};
	endfunction

	logic [26:0] st_a [1:DS];
	logic [26:0] st_b [1:DS];

	always_comb begin
		for (int k = 1; k <= DS; k++) begin
			st_a[k] = step(rem_s[k-1], dm_s[k-1]);
			st_b[k] = step(st_a[k][25:0], dm_s[k-1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DS; k++) vld_s[k] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_vld;
			for (int k = 1; k <= DS; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			spec_s[0]  <= u_spec;
			sbits_s[0] <= u_sbits;
			sgn_s[0]   <= u_sgn;
			qe_s[0]    <= u_qe;
			rem_s[0]   <= lt ? {1'b0, mx, 1'b0} : {2'b0, mx};
			dm_s[0]    <= me;
			qt_s[0]    <= 26'd0;
			aux_s[0]   <= aux_in;
			for (int k = 1; k <= DS; k++) begin
				spec_s[k]  <= spec_s[k-1];
				sbits_s[k] <= sbits_s[k-1];
				sgn_s[k]   <= sgn_s[k-1];
				qe_s[k]    <= qe_s[k-1];
				dm_s[k]    <= dm_s[k-1];
				aux_s[k]   <= aux_s[k-1];
				rem_s[k]   <= st_b[k][25:0];
				qt_s[k]    <= {qt_s[k-1][23:0], st_a[k][26], st_b[k][26]};
			end
		end
	end

	// denormalise for tiny quotients, flag overflow
	logic        f_ovf, f_st;
	logic [4:0]  f_sh;
	logic [25:0] f_m;
	logic [7:0]  f_exp;
	logic [10:0] f_neg;

	always_comb begin
		f_ovf = !qe_s[DS][10] && (qe_s[DS][9:0] >= 10'd255);
		f_st  = rem_s[DS] != 26'd0;
		f_neg = 11'd1 - qe_s[DS];
		f_sh  = 5'd0;
		f_exp = qe_s[DS][7:0];
		f_m   = qt_s[DS];
		if (qe_s[DS] < 11'sd1) begin
			f_sh  = (f_neg > 11'd26) ? 5'd26 : f_neg[4:0];
			f_exp = 8'd0;
			f_m   = qt_s[DS] >> f_sh;
			f_st  = f_st | (|(qt_s[DS] & ~(26'h3ffffff << f_sh)));
		end
	end

	logic        vld_s15, spec_s15, sgn_s15, ovf_s15, st_s15;
	logic [31:0] sbits_s15, aux_s15;
	logic [25:0] m_s15;
	logic [7:0]  exp_s15;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s15 <= 1'b0;
			out_vld <= 1'b0;
		end else if (adv) begin
			vld_s15 <= vld_s[DS];
			out_vld <= vld_s15;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			spec_s15  <= spec_s[DS];
			sbits_s15 <= sbits_s[DS];
			sgn_s15   <= sgn_s[DS];
			aux_s15   <= aux_s[DS];
			ovf_s15   <= f_ovf;
			st_s15    <= f_st;
			m_s15     <= f_m;
			exp_s15   <= f_exp;
		end
	end

	// round: carry out of the fraction walks into the exponent field
	logic        r_up;
	logic [30:0] r_mag;
	logic [31:0] r_bits;

	always_comb begin
		r_up  = m_s15[1] && (m_s15[0] || st_s15 || m_s15[2]);
		r_mag = {exp_s15, m_s15[24:2]} + {30'd0, r_up};
		if (spec_s15) begin
			r_bits = sbits_s15;
		end else if (ovf_s15) begin
			r_bits = {sgn_s15, POS_INF};
		end else begin
			r_bits = {sgn_s15, r_mag};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			quo     <= r_bits;
			aux_out <= aux_s15;
		end
	end

endmodule
`default_nettype wire

>>> rtl/fsn_add.sv
// Pipelined IEEE single-precision adder, round to nearest even.
// Five stages: swap, align, add, normalise, round. Depends on fsn_pkg.
`default_nettype none
module fsn_add (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        adv,
	input  wire logic        in_vld,
	input  wire logic [31:0] opa,
	input  wire logic [31:0] opb,
	output logic             out_vld,
	output logic      [31:0] sum
);
	import fsn_pkg::*;

	// swap so the larger magnitude leads
	logic        w_swap, w_spec, w_sub;
	logic [31:0] w_big, w_sml, w_sbits;
	logic [7:0]  w_el, w_es, w_d;

	always_comb begin
		w_swap = opa[30:0] < opb[30:0];
		w_big  = w_swap ? opb : opa;
		w_sml  = w_swap ? opa : opb;
		w_el   = (w_big[30:23] == 8'd0) ? 8'd1 : w_big[30:23];
		w_es   = (w_sml[30:23] == 8'd0) ? 8'd1 : w_sml[30:23];
		w_d    = w_el - w_es;
		w_sub  = opa[31] ^ opb[31];
		w_spec  = 1'b1;
		w_sbits = CANON_NAN;
		if (is_nan(opa) || is_nan(opb) || (is_inf(opa) && is_inf(opb) && w_sub)) begin
			w_sbits = CANON_NAN;
		end else if (is_inf(w_big)) begin
			w_sbits = w_big;
		end else begin
			w_spec = 1'b0;
		end
	end

	logic        vld_s1, spec_s1, sub_s1, sgn_s1;
	logic [31:0] sbits_s1;
	logic [7:0]  el_s1;
	logic [4:0]  d_s1;
	logic [23:0] ml_s1, ms_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			spec_s1  <= w_spec;
			sbits_s1 <= w_sbits;
			sub_s1   <= w_sub;
			sgn_s1   <= w_big[31];
			el_s1    <= w_el;
			d_s1     <= (w_d > 8'd27) ? 5'd27 : w_d[4:0];
			ml_s1    <= {w_big[30:23] != 8'd0, w_big[22:0]};
			ms_s1    <= {w_sml[30:23] != 8'd0, w_sml[22:0]};
		end
	end

	// align the smaller operand, folding lost bits into a sticky bit
	logic [26:0] a_ext, a_sh;
	logic        a_lost;

	always_comb begin
		a_ext  = {ms_s1, 3'b000};
		a_sh   = a_ext >> d_s1;
		a_lost = |(a_ext & ~(27'h7ffffff << d_s1));
	end

	logic        vld_s2, spec_s2, sub_s2, sgn_s2;
	logic [31:0] sbits_s2;
	logic [7:0]  el_s2;
	logic [23:0] ml_s2;
	logic [26:0] al_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			spec_s2  <= spec_s1;
			sbits_s2 <= sbits_s1;
			sub_s2   <= sub_s1;
			sgn_s2   <= sgn_s1;
			el_s2    <= el_s1;
			ml_s2    <= ml_s1;
			al_s2    <= {a_sh[26:1], a_sh[0] | a_lost};
		end
	end

	logic        vld_s3, spec_s3, sub_s3, sgn_s3;
	logic [31:0] sbits_s3;
	logic [7:0]  el_s3;
	logic [27:0] sum_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			spec_s3  <= spec_s2;
			sbits_s3 <= sbits_s2;
			sub_s3   <= sub_s2;
			sgn_s3   <= sgn_s2;
			el_s3    <= el_s2;
			sum_s3   <= sub_s2 ? {1'b0, ml_s2, 3'b000} - {1'b0, al_s2}
				: {1'b0, ml_s2, 3'b000} + {1'b0, al_s2};
		end
	end

	// normalise; left shift stops at the subnormal boundary
	logic [4:0]  n_lz, n_sh;
	logic [7:0]  n_elm1, n_exp;
	logic [26:0] n_m;
	logic        n_ovf, n_zero, n_sgn;

	always_comb begin
		n_lz   = lzc27(sum_s3[26:0]);
		n_elm1 = el_s3 - 8'd1;
		n_sh   = ({3'd0, n_lz} > n_elm1) ? n_elm1[4:0] : n_lz;
		n_zero = sum_s3 == 28'd0;
		n_sgn  = n_zero ? (sgn_s3 && !sub_s3) : sgn_s3;
		n_ovf  = 1'b0;
		if (sum_s3[27]) begin
			n_m   = {sum_s3[27:2], sum_s3[1] | sum_s3[0]};
			n_exp = el_s3 + 8'd1;
			n_ovf = el_s3 == 8'd254;
		end else begin
			n_m   = sum_s3[26:0] << n_sh;
			n_exp = n_m[26] ? el_s3 - {3'd0, n_sh} : 8'd0;
		end
	end

	logic        vld_s4, spec_s4, sgn_s4, ovf_s4;
	logic [31:0] sbits_s4;
	logic [7:0]  exp_s4;
	logic [26:0] m_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			spec_s4  <= spec_s3;
			sbits_s4 <= sbits_s3;
			sgn_s4   <= n_sgn;
			ovf_s4   <= n_ovf;
			exp_s4   <= n_exp;
			m_s4     <= n_m;
		end
	end

	logic        r_up;
	logic [30:0] r_mag;
	logic [31:0] r_bits;

	always_comb begin
		r_up  = m_s4[2] && (m_s4[1] || m_s4[0] || m_s4[3]);
		r_mag = {exp_s4, m_s4[25:3]} + {30'd0, r_up};
		if (spec_s4) begin
			r_bits = sbits_s4;
		end else if (ovf_s4) begin
			r_bits = {sgn_s4, POS_INF};
		end else begin
			r_bits = {sgn_s4, r_mag};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			out_vld <= 1'b0;
		end else if (adv) begin
			vld_s1  <= in_vld;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			out_vld <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum <= r_bits;
		end
	end

endmodule
`default_nettype wire

>>> rtl/fast_float_sqrt_newton_unit.sv
// Top level of the approximate single-precision square root pipeline.
// Instantiates fsn_div and fsn_add; depends on fsn_pkg.
`default_nettype none
// Approximate square root of an IEEE single-precision operand: the operand
// bits, halved arithmetically and offset by magic_offset, give an estimate e,
// then one Newton step 0.5*(e + x/e) runs in IEEE single precision with
// round to nearest even. Every NaN result comes out as 0x7fc00000. One
// operand is taken per clock while the output is not stalled. There are
// 1 estimate stage, 16 divider stages, 5 adder stages and 1 halving/output
// stage; the two-bits-per-stage divider is the longest. A stall
// on the output freezes the whole pipeline and stalls the input channel.
// magic_offset resets to 0x1fbb67a2 and is only to be written while idle.
module fast_float_sqrt_newton_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] operand_bits,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [31:0] root_bits,
	input  wire logic        cfg_we,
	input  wire logic [30:0] cfg_wdata
);
	import fsn_pkg::*;

	logic        adv;
	logic [30:0] magic_q;

	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= MAGIC_RESET;
		end else if (cfg_we) begin
			magic_q <= cfg_wdata;
		end
	end

	// initial estimate
	logic        vld_s1;
	logic [31:0] x_s1, e_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= operand_bits;
			e_s1 <= {operand_bits[31], operand_bits[31:1]} + {1'b0, magic_q};
		end
	end

	logic        q_vld;
	logic [31:0] q_bits, q_est;

	fsn_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (vld_s1),
		.num     (x_s1),
		.den     (e_s1),
		.aux_in  (e_s1),
		.out_vld (q_vld),
		.quo     (q_bits),
		.aux_out (q_est)
	);

	logic        s_vld;
	logic [31:0] s_bits;

	fsn_add u_add (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (q_vld),
		.opa     (q_est),
		.opb     (q_bits),
		.out_vld (s_vld),
		.sum     (s_bits)
	);

	// halve: exponent decrement, or a rounded shift for subnormal results
	logic [30:0] h_mag;
	logic [31:0] h_bits;

	always_comb begin
		h_mag = {1'b0, s_bits[30:1]};
		h_mag = h_mag + {30'd0, s_bits[0] & h_mag[0]};
		if (is_nan(s_bits)) begin
			h_bits = CANON_NAN;
		end else if (s_bits[30:23] == EXP_MAX) begin
			h_bits = s_bits;
		end else if (s_bits[30:23] >= 8'd2) begin
			h_bits = {s_bits[31], s_bits[30:23] - 8'd1, s_bits[22:0]};
		end else begin
			h_bits = {s_bits[31], h_mag};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= s_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			root_bits <= h_bits;
		end
	end

endmodule
`default_nettype wire
